/* hdl/cdg_pkg.sv */
// ----------------------------------------------------------------------------
// cdg_pkg
// Shared types and constants of the central-difference gradient unit.
// ----------------------------------------------------------------------------
package cdg_pkg;

    localparam int ROW_W      = 12;  // out_row and row counter
    localparam int OUT_COL_W  = 10;  // out_col field
    localparam int WIDTH_W    = 11;  // image_width register
    localparam int HEIGHT_W   = 12;  // image_height register
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // one bit per result kind, emitted lowest first
    localparam logic [2:0] RES_ABOVE = 3'b001;  // (r-1, c)
    localparam logic [2:0] RES_LEFT  = 3'b010;  // (r, c-1), last row only
    localparam logic [2:0] RES_HERE  = 3'b100;  // (r, c), last pixel of frame

    // position of an accepted pixel, decoded once at the input
    typedef struct packed {
        logic first_row;
        logic row_one;
        logic last_row;
        logic col_zero;
        logic col_one;
        logic last_col;
    } pos_flags_t;

endpackage

/* hdl/cdg_ram.sv */
// ----------------------------------------------------------------------------
// cdg_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module cdg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/cdg_ctl.sv */
// ----------------------------------------------------------------------------
// cdg_ctl
// Config registers and raster position tracking; decodes each pixel's place.
// ----------------------------------------------------------------------------
module cdg_ctl #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cdg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cdg_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             accept,
    output logic [$clog2(MAX_WIDTH)-1:0]     pos_col,
    output logic [$clog2(MAX_WIDTH)-1:0]     pos_col_next,
    output logic [cdg_pkg::ROW_W-1:0]        pos_row,
    output cdg_pkg::pos_flags_t              pos_flags
);
    import cdg_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [CW-1:0]       col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;

    logic [CW-1:0]    last_col;
    logic [ROW_W-1:0] last_row;
    logic             wrap_col;
    logic [CW-1:0]    c_eff;
    logic [ROW_W:0]   r_inc;
    logic [ROW_W-1:0] r_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_W'(640);
            height_reg <= HEIGHT_W'(480);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // width clamped to 2..MAX_WIDTH, height zero taken as one
    always_comb begin
        if (width_reg < WIDTH_W'(2)) begin
            last_col = CW'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            last_col = CW'(MAX_WIDTH - 1);
        end else begin
            last_col = CW'(width_reg - WIDTH_W'(1));
        end
        last_row = (height_reg == '0) ? '0 : ROW_W'(height_reg - HEIGHT_W'(1));
    end

    // a stored position beyond a shrunken size starts the next row / frame
    assign wrap_col = (col_reg > last_col);
    assign c_eff    = wrap_col ? '0 : col_reg;
    assign r_inc    = {1'b0, row_reg} + (ROW_W+1)'(wrap_col);
    assign r_eff    = (r_inc > {1'b0, last_row}) ? '0 : r_inc[ROW_W-1:0];

    always_comb begin
        if (c_eff == last_col) begin
            col_next = '0;
            row_next = (r_eff == last_row) ? '0 : r_eff + ROW_W'(1);
        end else begin
            col_next = c_eff + CW'(1);
            row_next = r_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign pos_col      = c_eff;
    assign pos_col_next = c_eff + CW'(1);
    assign pos_row      = r_eff;

    always_comb begin
        pos_flags.first_row = (r_eff == '0);
        pos_flags.row_one   = (r_eff == ROW_W'(1));
        pos_flags.last_row  = (r_eff == last_row);
        pos_flags.col_zero  = (c_eff == '0);
        pos_flags.col_one   = (c_eff == CW'(1));
        pos_flags.last_col  = (c_eff == last_col);
    end

    a_row_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> r_eff <= last_row)
        else $error("pixel row beyond frame height");

    a_col_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> c_eff <= last_col)
        else $error("pixel column beyond row width");

    a_edges_apart: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> !(pos_flags.col_zero && pos_flags.last_col))
        else $error("first and last column coincide");

endmodule

/* hdl/cdg_grad.sv */
// ----------------------------------------------------------------------------
// cdg_grad
// Work stage: line-buffer forwarding, gradient math, result sequencing and
// the output register.
// ----------------------------------------------------------------------------
module cdg_grad #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             accept,
    output logic                             in_ready,
    input  logic [PIXEL_BITS-1:0]            in_pixel,
    input  logic [$clog2(MAX_WIDTH)-1:0]     pos_col,
    input  logic [cdg_pkg::ROW_W-1:0]        pos_row,
    input  cdg_pkg::pos_flags_t              pos_flags,
    input  logic [PIXEL_BITS-1:0]            rd_mid,
    input  logic [PIXEL_BITS-1:0]            rd_nxt,
    input  logic [PIXEL_BITS-1:0]            rd_old2,
    output logic                             wr_en,
    output logic [$clog2(MAX_WIDTH)-1:0]     wr_addr,
    output logic [PIXEL_BITS-1:0]            wr_pix,
    output logic [PIXEL_BITS-1:0]            wr_mid,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [PIXEL_BITS:0]       out_grad_x,
    output logic signed [PIXEL_BITS:0]       out_grad_y,
    output logic [cdg_pkg::ROW_W-1:0]        out_row,
    output logic [cdg_pkg::OUT_COL_W-1:0]    out_col,
    output logic                             out_run_last,
    output logic                             out_frame_done
);
    import cdg_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int GW = PIXEL_BITS + 1;

    function automatic logic [GW-1:0] diff(input logic [PIXEL_BITS-1:0] a,
                                           input logic [PIXEL_BITS-1:0] b);
        return {1'b0, a} - {1'b0, b};
    endfunction

    // work stage
    logic                  st_valid_reg;
    logic [2:0]            pend_reg;
    logic [PIXEL_BITS-1:0] st_pix_reg;
    logic [CW-1:0]         st_col_reg;
    logic [ROW_W-1:0]      st_row_reg;
    pos_flags_t            st_flags_reg;

    // history of previous pixels
    logic [PIXEL_BITS-1:0] lp_reg, slp_reg, prev_mid_reg;

    // last line-buffer write, for same-edge read forwarding
    logic                  wrec_valid_reg;
    logic [CW-1:0]         wrec_addr_reg;
    logic [PIXEL_BITS-1:0] wrec_pix_reg, wrec_mid_reg;

    // output register
    logic                  m_valid_reg;
    logic [GW-1:0]         m_gx_reg, m_gy_reg;
    logic [ROW_W-1:0]      m_row_reg;
    logic [OUT_COL_W-1:0]  m_col_reg;
    logic                  m_last_reg, m_done_reg;

    logic                  hit_mid, hit_nxt;
    logic [PIXEL_BITS-1:0] old_mid, nxt, old2, up;
    logic [GW-1:0]         a_gx, a_gy, b_gx, b_gy, c_gx, c_gy;
    logic [2:0]            pick, pend_after, pend_init;
    logic                  out_free, emit, leave;
    logic [GW-1:0]         sel_gx, sel_gy;
    logic [ROW_W-1:0]      sel_row;
    logic [CW-1:0]         sel_col;

    assign hit_mid = wrec_valid_reg && (wrec_addr_reg == st_col_reg);
    assign hit_nxt = wrec_valid_reg && (wrec_addr_reg == st_col_reg + CW'(1));
    assign old_mid = hit_mid ? wrec_pix_reg : rd_mid;
    assign nxt     = hit_nxt ? wrec_pix_reg : rd_nxt;
    assign old2    = hit_mid ? wrec_mid_reg : rd_old2;
    assign up      = st_flags_reg.row_one ? old_mid : old2;

    // row above: (r-1, c); row r-1 at c-1 is the previous pixel's old_mid
    always_comb begin
        if (st_flags_reg.col_zero) begin
            a_gx = diff(nxt, old_mid);
        end else if (st_flags_reg.last_col) begin
            a_gx = diff(old_mid, prev_mid_reg);
        end else begin
            a_gx = diff(nxt, prev_mid_reg);
        end
        a_gy = diff(st_pix_reg, up);
        b_gx = st_flags_reg.col_one ? diff(st_pix_reg, lp_reg) : diff(st_pix_reg, slp_reg);
        b_gy = st_flags_reg.first_row ? '0 : diff(lp_reg, prev_mid_reg);
        c_gx = diff(st_pix_reg, lp_reg);
        c_gy = st_flags_reg.first_row ? '0 : diff(st_pix_reg, old_mid);
    end

    assign pick       = pend_reg & (~pend_reg + 3'd1);
    assign out_free   = !m_valid_reg || out_ready;
    assign emit       = st_valid_reg && (pend_reg != '0) && out_free;
    assign pend_after = emit ? (pend_reg & ~pick) : pend_reg;
    assign leave      = st_valid_reg && (pend_after == '0);
    assign in_ready   = !st_valid_reg || leave;

    assign pend_init = (pos_flags.first_row ? 3'b000 : RES_ABOVE)
                     | ((pos_flags.last_row && !pos_flags.col_zero) ? RES_LEFT : 3'b000)
                     | ((pos_flags.last_row && pos_flags.last_col) ? RES_HERE : 3'b000);

    always_comb begin
        case (pick)
            RES_ABOVE: begin
                sel_gx  = a_gx;
                sel_gy  = a_gy;
                sel_row = st_row_reg - ROW_W'(1);
                sel_col = st_col_reg;
            end
            RES_LEFT: begin
                sel_gx  = b_gx;
                sel_gy  = b_gy;
                sel_row = st_row_reg;
                sel_col = st_col_reg - CW'(1);
            end
            default: begin
                sel_gx  = c_gx;
                sel_gy  = c_gy;
                sel_row = st_row_reg;
                sel_col = st_col_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
            pend_reg     <= '0;
        end else if (accept) begin
            st_valid_reg <= 1'b1;
            pend_reg     <= pend_init;
        end else begin
            if (leave) begin
                st_valid_reg <= 1'b0;
            end
            pend_reg <= pend_after;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_pix_reg   <= in_pixel;
            st_col_reg   <= pos_col;
            st_row_reg   <= pos_row;
            st_flags_reg <= pos_flags;
        end
        if (leave) begin
            lp_reg        <= st_pix_reg;
            slp_reg       <= lp_reg;
            prev_mid_reg  <= old_mid;
            wrec_addr_reg <= st_col_reg;
            wrec_pix_reg  <= st_pix_reg;
            wrec_mid_reg  <= old_mid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wrec_valid_reg <= 1'b0;
        end else if (leave) begin
            wrec_valid_reg <= 1'b1;
        end
    end

    assign wr_en   = leave;
    assign wr_addr = st_col_reg;
    assign wr_pix  = st_pix_reg;
    assign wr_mid  = old_mid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (out_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_gx_reg   <= sel_gx;
            m_gy_reg   <= sel_gy;
            m_row_reg  <= sel_row;
            m_col_reg  <= OUT_COL_W'(sel_col);
            m_last_reg <= (pend_after == '0);
            m_done_reg <= (pick == RES_HERE);
        end
    end

    assign out_valid      = m_valid_reg;
    assign out_grad_x     = $signed(m_gx_reg);
    assign out_grad_y     = $signed(m_gy_reg);
    assign out_row        = m_row_reg;
    assign out_col        = m_col_reg;
    assign out_run_last   = m_last_reg;
    assign out_frame_done = m_done_reg;

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_done_reg |-> m_last_reg)
        else $error("frame end not on last beat of its pixel");

    a_hold_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        st_valid_reg && (pend_reg != '0) && m_valid_reg && !out_ready |-> !in_ready)
        else $error("input taken while results still pending");

    a_write_record: assert property (@(posedge aclk) disable iff (!aresetn)
        leave |=> wrec_valid_reg && (wrec_addr_reg == $past(st_col_reg)))
        else $error("forwarding record does not track line write");

endmodule

/* hdl/central_difference_gradient_xy_unit.sv */
// ----------------------------------------------------------------------------
// central_difference_gradient_xy_unit
// Raster-stream central-difference gradient (x and y), one-row latency.
// ----------------------------------------------------------------------------
// Takes one pixel per beat in raster order and returns, per pixel, twice the
// horizontal and vertical gradient (exact, one implied fraction bit), with the
// row and column described. Results lag one row: the pixel at (r, c) finishes
// the result for (r-1, c); on the frame's last row each pixel also gives the
// result for its left neighbour, and the last pixel of the frame gives its own
// result too, flagged frame_done. run_last marks the final result of a pixel.
// Throughput is one pixel per clock while the output is not stalled; a
// last-row pixel past column 0 holds the input longer (two results) and the
// frame's final pixel longer still (three), since the output register moves
// one result per clock. A pixel is registered in the work stage, its results
// then in the output register until taken. The previous two rows live in two
// MAX_WIDTH-deep RAMs with registered reads: one holds the previous row and
// the row before it side by side, the other a second copy of the previous row
// for the read one column to the right; no clearing pass is needed after
// reset. Configuration (image_width, image_height) is to be written by the
// user only while the block is idle, which the block does not enforce; the
// width is clamped to 2..MAX_WIDTH and a zero height counts as one.
// ----------------------------------------------------------------------------
module central_difference_gradient_xy_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cdg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cdg_pkg::CFG_DATA_W-1:0]    cfg_data,
    // pixel input
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [PIXEL_BITS-1:0]             s_pixel,
    // gradient output
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [PIXEL_BITS:0]        m_grad_x,
    output logic signed [PIXEL_BITS:0]        m_grad_y,
    output logic [cdg_pkg::ROW_W-1:0]         m_out_row,
    output logic [cdg_pkg::OUT_COL_W-1:0]     m_out_col,
    output logic                              m_run_last,
    output logic                              m_frame_done
);
    import cdg_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic                    accept;
    logic [CW-1:0]           pos_col, pos_col_next;
    logic [ROW_W-1:0]        pos_row;
    pos_flags_t              pos_flags;

    logic [PIXEL_BITS-1:0]   rd_mid, rd_nxt, rd_old2;
    logic [2*PIXEL_BITS-1:0] rd_pair;
    logic                    wr_en;
    logic [CW-1:0]           wr_addr;
    logic [PIXEL_BITS-1:0]   wr_pix, wr_mid;

    // one beat in: position decoded and line reads issued on the same edge
    assign accept = s_valid && s_ready;

    cdg_ctl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .pos_col      (pos_col),
        .pos_col_next (pos_col_next),
        .pos_row      (pos_row),
        .pos_flags    (pos_flags)
    );

    // previous row (upper half) and the row before it (lower half), both
    // read at the pixel's column
    cdg_ram #(
        .WIDTH (2*PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_prev_pair (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata ({wr_pix, wr_mid}),
        .re    (accept),
        .raddr (pos_col),
        .rdata (rd_pair)
    );

    assign rd_mid  = rd_pair[2*PIXEL_BITS-1:PIXEL_BITS];
    assign rd_old2 = rd_pair[PIXEL_BITS-1:0];

    // previous row again, read one column to the right
    cdg_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_prev_nxt (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_pix),
        .re    (accept),
        .raddr (pos_col_next),
        .rdata (rd_nxt)
    );

    // math, write-back and result sequencing; the output register decouples
    // the sides so a new pixel enters while a result waits
    cdg_grad #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_grad (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .in_ready       (s_ready),
        .in_pixel       (s_pixel),
        .pos_col        (pos_col),
        .pos_row        (pos_row),
        .pos_flags      (pos_flags),
        .rd_mid         (rd_mid),
        .rd_nxt         (rd_nxt),
        .rd_old2        (rd_old2),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_pix         (wr_pix),
        .wr_mid         (wr_mid),
        .out_valid      (m_valid),
        .out_ready      (m_ready),
        .out_grad_x     (m_grad_x),
        .out_grad_y     (m_grad_y),
        .out_row        (m_out_row),
        .out_col        (m_out_col),
        .out_run_last   (m_run_last),
        .out_frame_done (m_frame_done)
    );

endmodule
